// ===== src/mfsgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mfsgd_pkg;

    // Fixed field widths
    localparam int DATA_W   = 16;
    localparam int RATING_W = 15;
    localparam int SUM_W    = 48;

    // Shared multiplier operand and product widths
    localparam int A_W = 34;
    localparam int B_W = 17;
    localparam int P_W = A_W + B_W;

    // Update accumulator: own value at bit 32 plus the scaled gradient
    localparam int G_W = 56;
    localparam logic signed [G_W-1:0] G_HALF = 56'sh0000_0080_0000_00 >>> 0;

    // Saturation input width
    localparam int SAT_W = 40;

    // Prediction rounding and clamp
    localparam int RND_SHIFT = 12;
    localparam int RND_HALF  = 2048;
    localparam logic signed [DATA_W-1:0] RATING_CAP = 16'sd20480;

    // Register reset values
    localparam logic [DATA_W-1:0] LR_RESET  = 16'd655;
    localparam logic [DATA_W-1:0] REG_RESET = 16'd655;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_IDX_LR  = 1'b0;
    localparam logic REG_IDX_REG = 1'b1;

    // Row reduction steps for the modulo by the user and item counts
    localparam logic [3:0] MOD_LAST_STEP = 4'd9;

    // Command codes
    localparam logic [1:0] CMD_TRAIN   = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    // Multiplier request
    typedef struct packed {
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
    } t_mul_req;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MOD,
        S_DRD,
        S_DMUL,
        S_DACC,
        S_PRED,
        S_ERR,
        S_SQ,
        S_LE,
        S_LR,
        S_LRT,
        S_URD,
        S_UM0,
        S_UM1,
        S_UM2,
        S_UM3,
        S_UWR,
        S_UWB,
        S_LOAD,
        S_FIN
    } t_state;

    // Saturate to a signed 16-bit value
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 40'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/mfsgd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfsgd_ram #(
    parameter int AW = 14
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic                              i_re,
    input  wire logic [AW-1:0]                     i_addr,
    input  wire logic [mfsgd_pkg::DATA_W-1:0]      i_wdata,
    output logic      [mfsgd_pkg::DATA_W-1:0]      o_rdata
);

    logic [mfsgd_pkg::DATA_W-1:0] r_mem [2**AW];
    logic [mfsgd_pkg::DATA_W-1:0] r_rdata;

    // Write on request, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/mfsgd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfsgd_mul (
    input  wire logic                               i_clk,
    input  wire mfsgd_pkg::t_mul_req                i_req,
    output logic signed [mfsgd_pkg::P_W-1:0]        o_p
);

    logic signed [mfsgd_pkg::P_W-1:0] r_p;

    // Register the signed product
    always_ff @(posedge i_clk) begin
        r_p <= i_req.a * i_req.b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== src/matrix_factorization_sgd_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_stall     | command, ids, rating, load fields
// output    | out       | o_out_valid / i_out_stall   | prediction, error, epoch sum/done
// config    | in        | APB psel/penable/pready     | learning_rate, regularization
//
// Work runs through one shared registered multiplier and one factor-table port per table.
// A transaction is taken only while the sequencer is idle; one item is in work at a time.
// Reset (synchronous, active low) clears the sequencer, the output valid and the epoch sum,
// sets the registers to their reset values; the factor tables hold nothing until loaded.
// A stalled result waits in the output register; the next transaction is still taken.
module matrix_factorization_sgd_unit #(
    parameter int NUM_FACTORS = 16,
    parameter int NUM_USERS   = 1024,
    parameter int NUM_ITEMS   = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_command,
    input  wire logic [9:0]           i_user_id,
    input  wire logic [9:0]           i_item_id,
    input  wire logic [14:0]          i_rating,
    input  wire logic                 i_last_rating,
    input  wire logic                 i_factor_target,
    input  wire logic [3:0]           i_factor_index,
    input  wire logic signed [15:0]   i_factor_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [15:0]        o_prediction,
    output logic signed [15:0]        o_error,
    output logic [47:0]               o_epoch_error_sum,
    output logic                      o_epoch_done,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int FW      = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
    localparam int UROW_W  = (NUM_USERS > 1024) ? 10 : $clog2(NUM_USERS);
    localparam int IROW_W  = (NUM_ITEMS > 1024) ? 10 : $clog2(NUM_ITEMS);
    localparam int UAW     = UROW_W + FW;
    localparam int IAW     = IROW_W + FW;
    localparam int ACC_W   = 33 + FW;
    localparam logic [FW-1:0]   F_LAST = FW'(NUM_FACTORS - 1);
    localparam logic [26:0]     USERS_W = 27'(NUM_USERS);
    localparam logic [26:0]     ITEMS_W = 27'(NUM_ITEMS);

    localparam int DW = mfsgd_pkg::DATA_W;

    mfsgd_pkg::t_state r_state, n_state;

    // Latched transaction
    logic [1:0]              r_cmd;
    logic [9:0]              r_uid, r_iid;
    logic [14:0]             r_rating;
    logic                    r_last, r_tgt;
    logic [3:0]              r_fidx;
    logic signed [DW-1:0]    r_fval;

    // Sequencer counters and datapath
    logic [3:0]                       r_k;
    logic [FW-1:0]                    r_f;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [DW-1:0]             r_pred, r_err;
    logic signed [32:0]               r_le;
    logic [31:0]                      r_lrg;
    logic signed [mfsgd_pkg::G_W-1:0] r_gu, r_gi;
    logic [mfsgd_pkg::SUM_W-1:0]      r_sum;
    logic [DW-1:0]                    r_lr, r_reg;
    logic                             r_ov;

    // Shared multiplier
    mfsgd_pkg::t_mul_req              mul_req;
    logic signed [mfsgd_pkg::P_W-1:0] mul_p;

    // Table ports
    logic                 u_we, u_re, i_we, i_re;
    logic [UAW-1:0]       u_addr;
    logic [IAW-1:0]       i_addr;
    logic [DW-1:0]        u_wdata, i_wdata;
    logic [DW-1:0]        u_rdata_raw, i_rdata_raw;
    logic signed [DW-1:0] u_rdata, i_rdata;

    logic                 in_acc, fin_go, cfg_wr, f_last;
    logic                 uid_ge, iid_ge, fidx_ok;
    logic [FW+3:0]        fidx_w;
    logic signed [ACC_W:0] acc_rnd;
    logic signed [DW-1:0] pred_sat, pred_clamp, err_sat, new_u, new_i;
    logic [mfsgd_pkg::SUM_W:0] sum_nx;

    assign u_rdata = signed'(u_rdata_raw);
    assign i_rdata = signed'(i_rdata_raw);

    mfsgd_ram #(.AW(UAW)) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_re    (u_re),
        .i_addr  (u_addr),
        .i_wdata (u_wdata),
        .o_rdata (u_rdata_raw)
    );

    mfsgd_ram #(.AW(IAW)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_re    (i_re),
        .i_addr  (i_addr),
        .i_wdata (i_wdata),
        .o_rdata (i_rdata_raw)
    );

    mfsgd_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    // Handshake decode
    assign in_acc = i_in_valid && !o_in_stall;
    assign fin_go = (r_state == mfsgd_pkg::S_FIN) && (!r_ov || !i_out_stall);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign f_last = (r_f == F_LAST);

    // Row reduction compares
    assign uid_ge = (27'(r_uid) >= (USERS_W << r_k));
    assign iid_ge = (27'(r_iid) >= (ITEMS_W << r_k));

    // Load index check
    assign fidx_w  = {FW'(0), r_fidx};
    assign fidx_ok = (fidx_w < (FW + 4)'(NUM_FACTORS));

    // Prediction, error, sum and factor results
    assign acc_rnd    = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(mfsgd_pkg::RND_HALF);
    assign pred_sat   = mfsgd_pkg::sat16(40'(acc_rnd >>> mfsgd_pkg::RND_SHIFT));
    assign pred_clamp = (pred_sat < 16'sd0) ? 16'sd0 :
                        ((pred_sat > mfsgd_pkg::RATING_CAP) ? mfsgd_pkg::RATING_CAP : pred_sat);
    assign err_sat    = mfsgd_pkg::sat16(40'(signed'({1'b0, r_rating})) - 40'(r_pred));
    assign sum_nx     = {1'b0, r_sum} + 49'(mul_p[31:0]);
    assign new_u      = mfsgd_pkg::sat16(40'(signed'(r_gu[55:32])));
    assign new_i      = mfsgd_pkg::sat16(40'(signed'(r_gi[55:32])));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfsgd_pkg::S_IDLE: if (in_acc) n_state = mfsgd_pkg::S_MOD;
            mfsgd_pkg::S_MOD: begin
                if (r_k == 4'd0) begin
                    if (r_cmd == mfsgd_pkg::CMD_TRAIN || r_cmd == mfsgd_pkg::CMD_PREDICT) begin
                        n_state = mfsgd_pkg::S_DRD;
                    end else if (r_cmd == mfsgd_pkg::CMD_LOAD) begin
                        n_state = mfsgd_pkg::S_LOAD;
                    end else begin
                        n_state = mfsgd_pkg::S_FIN;
                    end
                end
            end
            mfsgd_pkg::S_DRD:  n_state = mfsgd_pkg::S_DMUL;
            mfsgd_pkg::S_DMUL: n_state = mfsgd_pkg::S_DACC;
            mfsgd_pkg::S_DACC: n_state = f_last ? mfsgd_pkg::S_PRED : mfsgd_pkg::S_DRD;
            mfsgd_pkg::S_PRED: begin
                n_state = (r_cmd == mfsgd_pkg::CMD_PREDICT) ? mfsgd_pkg::S_FIN
                                                            : mfsgd_pkg::S_ERR;
            end
            mfsgd_pkg::S_ERR:  n_state = mfsgd_pkg::S_SQ;
            mfsgd_pkg::S_SQ:   n_state = mfsgd_pkg::S_LE;
            mfsgd_pkg::S_LE:   n_state = mfsgd_pkg::S_LR;
            mfsgd_pkg::S_LR:   n_state = mfsgd_pkg::S_LRT;
            mfsgd_pkg::S_LRT:  n_state = mfsgd_pkg::S_URD;
            mfsgd_pkg::S_URD:  n_state = mfsgd_pkg::S_UM0;
            mfsgd_pkg::S_UM0:  n_state = mfsgd_pkg::S_UM1;
            mfsgd_pkg::S_UM1:  n_state = mfsgd_pkg::S_UM2;
            mfsgd_pkg::S_UM2:  n_state = mfsgd_pkg::S_UM3;
            mfsgd_pkg::S_UM3:  n_state = mfsgd_pkg::S_UWR;
            mfsgd_pkg::S_UWR:  n_state = mfsgd_pkg::S_UWB;
            mfsgd_pkg::S_UWB:  n_state = f_last ? mfsgd_pkg::S_FIN : mfsgd_pkg::S_URD;
            mfsgd_pkg::S_LOAD: n_state = mfsgd_pkg::S_FIN;
            mfsgd_pkg::S_FIN:  if (fin_go) n_state = mfsgd_pkg::S_IDLE;
            default:           n_state = mfsgd_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: stall, table ports, multiplier operands
    always_comb begin
        o_in_stall = (r_state != mfsgd_pkg::S_IDLE);
        u_we    = 1'b0;
        i_we    = 1'b0;
        u_re    = 1'b0;
        i_re    = 1'b0;
        u_addr  = {r_uid[UROW_W-1:0], r_f};
        i_addr  = {r_iid[IROW_W-1:0], r_f};
        u_wdata = new_u;
        i_wdata = new_i;
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            mfsgd_pkg::S_DRD, mfsgd_pkg::S_URD: begin
                u_re = 1'b1;
                i_re = 1'b1;
            end
            mfsgd_pkg::S_DMUL: begin
                mul_req.a = mfsgd_pkg::A_W'(u_rdata);
                mul_req.b = mfsgd_pkg::B_W'(i_rdata);
            end
            mfsgd_pkg::S_SQ: begin
                mul_req.a = mfsgd_pkg::A_W'(r_err);
                mul_req.b = mfsgd_pkg::B_W'(r_err);
            end
            mfsgd_pkg::S_LE: begin
                mul_req.a = mfsgd_pkg::A_W'({1'b0, r_lr});
                mul_req.b = mfsgd_pkg::B_W'(r_err);
            end
            mfsgd_pkg::S_LR: begin
                mul_req.a = mfsgd_pkg::A_W'({1'b0, r_lr});
                mul_req.b = {1'b0, r_reg};
            end
            mfsgd_pkg::S_UM0: begin
                mul_req.a = mfsgd_pkg::A_W'(r_le);
                mul_req.b = mfsgd_pkg::B_W'(i_rdata);
            end
            mfsgd_pkg::S_UM1: begin
                mul_req.a = mfsgd_pkg::A_W'({1'b0, r_lrg});
                mul_req.b = mfsgd_pkg::B_W'(u_rdata);
            end
            mfsgd_pkg::S_UM2: begin
                mul_req.a = mfsgd_pkg::A_W'(r_le);
                mul_req.b = mfsgd_pkg::B_W'(u_rdata);
            end
            mfsgd_pkg::S_UM3: begin
                mul_req.a = mfsgd_pkg::A_W'({1'b0, r_lrg});
                mul_req.b = mfsgd_pkg::B_W'(i_rdata);
            end
            mfsgd_pkg::S_UWB: begin
                u_we = 1'b1;
                i_we = 1'b1;
            end
            mfsgd_pkg::S_LOAD: begin
                u_addr  = {r_uid[UROW_W-1:0], fidx_w[FW-1:0]};
                i_addr  = {r_iid[IROW_W-1:0], fidx_w[FW-1:0]};
                u_wdata = r_fval;
                i_wdata = r_fval;
                u_we    = fidx_ok && !r_tgt;
                i_we    = fidx_ok && r_tgt;
            end
            default: begin
            end
        endcase
    end

    // Control state: sequencer, output valid, epoch sum, registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfsgd_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_sum   <= '0;
            r_lr    <= mfsgd_pkg::LR_RESET;
            r_reg   <= mfsgd_pkg::REG_RESET;
        end else begin
            r_state <= n_state;
            // hold the result until taken
            if (fin_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            // accumulate the squared error, saturating
            if (r_state == mfsgd_pkg::S_LE) begin
                r_sum <= sum_nx[mfsgd_pkg::SUM_W] ? '1 : sum_nx[mfsgd_pkg::SUM_W-1:0];
            end else if (fin_go && r_cmd == mfsgd_pkg::CMD_TRAIN && r_last) begin
                r_sum <= '0;
            end
            if (cfg_wr) begin
                if (paddr[2] == mfsgd_pkg::REG_IDX_LR) begin
                    r_lr <= pwdata[DW-1:0];
                end else begin
                    r_reg <= pwdata[DW-1:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mfsgd_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_cmd    <= i_command;
                    r_uid    <= i_user_id;
                    r_iid    <= i_item_id;
                    r_rating <= i_rating;
                    r_last   <= i_last_rating;
                    r_tgt    <= i_factor_target;
                    r_fidx   <= i_factor_index;
                    r_fval   <= i_factor_value;
                    r_k      <= mfsgd_pkg::MOD_LAST_STEP;
                end
            end
            mfsgd_pkg::S_MOD: begin
                // reduce the rows one binary step at a time
                if (uid_ge) r_uid <= r_uid - 10'((USERS_W << r_k));
                if (iid_ge) r_iid <= r_iid - 10'((ITEMS_W << r_k));
                r_k   <= r_k - 4'd1;
                r_f   <= '0;
                r_acc <= '0;
            end
            mfsgd_pkg::S_DACC: begin
                r_acc <= r_acc + ACC_W'(mul_p);
                r_f   <= f_last ? '0 : r_f + FW'(1);
            end
            mfsgd_pkg::S_PRED: begin
                r_pred <= (r_cmd == mfsgd_pkg::CMD_PREDICT) ? pred_clamp : pred_sat;
            end
            mfsgd_pkg::S_ERR: r_err <= err_sat;
            mfsgd_pkg::S_LR:  r_le  <= mul_p[32:0];
            mfsgd_pkg::S_LRT: r_lrg <= mul_p[31:0];
            mfsgd_pkg::S_UM1: begin
                r_gu <= (mfsgd_pkg::G_W'(u_rdata) <<< 32) + mfsgd_pkg::G_HALF
                        + (mfsgd_pkg::G_W'(mul_p) <<< 4);
            end
            mfsgd_pkg::S_UM2: r_gu <= r_gu - mfsgd_pkg::G_W'(mul_p);
            mfsgd_pkg::S_UM3: begin
                r_gi <= (mfsgd_pkg::G_W'(i_rdata) <<< 32) + mfsgd_pkg::G_HALF
                        + (mfsgd_pkg::G_W'(mul_p) <<< 4);
            end
            mfsgd_pkg::S_UWR: r_gi <= r_gi - mfsgd_pkg::G_W'(mul_p);
            mfsgd_pkg::S_UWB: r_f  <= f_last ? '0 : r_f + FW'(1);
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            if (r_cmd == mfsgd_pkg::CMD_TRAIN) begin
                o_prediction      <= r_pred;
                o_error           <= r_err;
                o_epoch_error_sum <= r_last ? r_sum : '0;
                o_epoch_done      <= r_last;
            end else begin
                o_prediction      <= (r_cmd == mfsgd_pkg::CMD_PREDICT) ? r_pred : '0;
                o_error           <= '0;
                o_epoch_error_sum <= '0;
                o_epoch_done      <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;

    // Register read-back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mfsgd_pkg::REG_IDX_REG) ? {16'd0, r_reg} : {16'd0, r_lr};

`ifndef SYNTHESIS
    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> o_out_valid)
        else $error("finished result not presented");

    a_sum_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_epoch_done) |-> (o_epoch_error_sum == '0))
        else $error("epoch sum shown without epoch end");

    a_idle_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == mfsgd_pkg::S_MOD && r_k == mfsgd_pkg::MOD_LAST_STEP))
        else $error("transaction not started cleanly");
`endif

endmodule
`default_nettype wire
